FILE: hw/rtl/sfrt_pkg.sv
// ----------------------------------------------------------------------------
// sfrt_pkg
// Shared types and constants of the sniffed frame source rssi table.
// ----------------------------------------------------------------------------
`default_nettype none

package sfrt_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned QueueDepth        = 2;

  // request kinds on the input stream
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // frame filter
  localparam logic [11:0] MinFrameLen  = 12'd24;
  localparam logic [1:0]  FcTypeData   = 2'd2;
  localparam int unsigned FcTypeLsb    = 2;
  localparam int unsigned FcToDsBit    = 8;
  localparam int unsigned FcFromDsBit  = 9;
  localparam int unsigned MacGroupBit  = 40;

  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_FILTER,
    OP_CLEAR,
    OP_READ,
    OP_FRAME
  } op_e;

  typedef enum logic [2:0] {
    OUT_FILTERED  = 3'd0,
    OUT_UPDATED   = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_FULL      = 3'd3,
    OUT_READ_OK   = 3'd4,
    OUT_BAD_INDEX = 3'd5,
    OUT_CLEARED   = 3'd6
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MISS,
    ST_READ,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_WRITE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [47:0]       mac;
    logic signed [7:0] rssi;
    logic [3:0]        read_index;
  } cmd_t;

  typedef struct packed {
    logic [47:0]       mac;
    logic signed [7:0] avg;
    logic [15:0]       cnt;
  } entry_t;

  typedef struct packed {
    outcome_e          outcome;
    logic [3:0]        slot;
    logic [47:0]       mac;
    logic signed [7:0] avg;
    logic [15:0]       count;
    logic [4:0]        entry_count;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfrt_front.sv
// ----------------------------------------------------------------------------
// sfrt_front
// Input side: unpacks a beat, applies the frame filter and forms a command.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_front (
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [87:0]      s_axis_tdata,
  input  wire logic [2:0]       s_axis_tuser,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output sfrt_pkg::cmd_t        q_cmd_o
);
  import sfrt_pkg::*;

  logic [1:0]        req_type;
  logic              is_data_frame;
  logic [11:0]       signal_length;
  logic [15:0]       frame_control;
  logic [47:0]       source_mac;
  logic signed [7:0] signal_strength;
  logic [3:0]        read_index;
  logic              frame_ok;

  assign req_type        = s_axis_tuser[1:0];
  assign is_data_frame   = s_axis_tuser[2];
  assign signal_length   = s_axis_tdata[11:0];
  assign frame_control   = s_axis_tdata[27:12];
  assign source_mac      = s_axis_tdata[75:28];
  assign signal_strength = $signed(s_axis_tdata[83:76]);
  assign read_index      = s_axis_tdata[87:84];

  assign frame_ok = is_data_frame
                 && (signal_length >= MinFrameLen)
                 && (frame_control[FcTypeLsb +: 2] == FcTypeData)
                 && !frame_control[FcToDsBit]
                 && !frame_control[FcFromDsBit]
                 && !source_mac[MacGroupBit];

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_cmd_o.mac        = source_mac;
    q_cmd_o.rssi       = signal_strength;
    q_cmd_o.read_index = read_index;
    case (req_type)
      REQ_FRAME: q_cmd_o.op = frame_ok ? OP_FRAME : OP_FILTER;
      REQ_CLEAR: q_cmd_o.op = OP_CLEAR;
      REQ_READ:  q_cmd_o.op = OP_READ;
      default:   q_cmd_o.op = OP_FILTER;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfrt_queue.sv
// ----------------------------------------------------------------------------
// sfrt_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sfrt_pkg::cmd_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output sfrt_pkg::cmd_t      head_o
);
  import sfrt_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  cmd_t             buf_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfrt_back.sv
// ----------------------------------------------------------------------------
// sfrt_back
// Table engine: serial search, insert, multiply and 8-step divide of the
// running average, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrt_back #(
  parameter int unsigned TableDepth = sfrt_pkg::TableDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire sfrt_pkg::cmd_t q_head_i,
  output logic                q_pop_o,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output sfrt_pkg::res_t      out_res_o
);
  import sfrt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned CmpW = (CntW > 4) ? CntW : 4;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic [CntW-1:0]    used_q, used_d;
  outcome_e           kind_q, kind_d;
  logic signed [7:0]  avg_q, avg_d;
  logic [15:0]        cnt_q, cnt_d;
  logic signed [24:0] prod_q, prod_d;
  logic [24:0]        rem_q, rem_d;
  logic [24:0]        dsh_q, dsh_d;
  logic               neg_q, neg_d;
  logic [7:0]         quo_q, quo_d;
  logic [2:0]         step_q, step_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;

  entry_t             table_q [TableDepth];
  entry_t             rd_data_q;
  entry_t             wr_data;
  logic               mem_re, mem_we;
  logic [IdxW-1:0]    rd_addr;

  logic               out_free, take, read_ok, last, hit, full, ge;
  logic [CmpW-1:0]    ridx_ext;
  logic [CntW-1:0]    idx_inc;
  logic [16:0]        dvs;
  logic signed [24:0] sum, a_ext, c_ext;
  logic signed [7:0]  new_avg;
  logic [15:0]        new_cnt;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = (state_q == ST_IDLE) && !q_empty_i && out_free;
  assign ridx_ext = CmpW'(q_head_i.read_index);
  assign read_ok  = (ridx_ext < CmpW'(used_q)) && (ridx_ext < CmpW'(TableDepth));
  assign idx_inc  = CntW'(idx_q) + CntW'(1);
  assign last     = (idx_inc >= used_q);
  assign hit      = (rd_data_q.mac == cmd_q.mac);
  assign full     = (used_q >= CntW'(TableDepth));
  assign a_ext    = 25'(avg_q);
  assign c_ext    = $signed(25'(cnt_q));
  assign sum      = prod_q + 25'(cmd_q.rssi);
  assign dvs      = 17'(cnt_q) + 17'd1;
  assign ge       = (rem_q >= dsh_q);
  assign new_avg  = neg_q ? $signed(-quo_q) : $signed(quo_q);
  assign new_cnt  = (cnt_q == CountMax) ? cnt_q : cnt_q + 16'd1;
  assign wr_data  = '{mac: cmd_q.mac, avg: new_avg, cnt: new_cnt};

  assign q_pop_o     = take;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (q_head_i.op)
            OP_READ:  state_d = read_ok ? ST_READ : ST_IDLE;
            OP_FRAME: state_d = (used_q != '0) ? ST_SEARCH : ST_MISS;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_d = ST_MUL;
        end else if (last) begin
          state_d = ST_MISS;
        end
      end
      ST_MISS:  state_d = full ? ST_IDLE : ST_MUL;
      ST_READ:  state_d = ST_IDLE;
      ST_MUL:   state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV:   state_d = (step_q == 3'd7) ? ST_WRITE : ST_DIV;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    used_d      = used_q;
    kind_d      = kind_q;
    avg_d       = avg_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_d = q_head_i;
          case (q_head_i.op)
            OP_CLEAR: begin
              used_d            = '0;
              out_valid_d       = 1'b1;
              out_d             = '0;
              out_d.outcome     = OUT_CLEARED;
            end
            OP_READ: begin
              if (read_ok) begin
                mem_re  = 1'b1;
                rd_addr = ridx_ext[IdxW-1:0];
                slot_d  = ridx_ext[IdxW-1:0];
              end else begin
                out_valid_d       = 1'b1;
                out_d             = '0;
                out_d.outcome     = OUT_BAD_INDEX;
                out_d.entry_count = 5'(used_q);
              end
            end
            OP_FRAME: begin
              if (used_q != '0) begin
                mem_re  = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
              end
            end
            default: begin
              out_valid_d       = 1'b1;
              out_d             = '0;
              out_d.outcome     = OUT_FILTERED;
              out_d.entry_count = 5'(used_q);
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          slot_d = idx_q;
          avg_d  = rd_data_q.avg;
          cnt_d  = rd_data_q.cnt;
          kind_d = OUT_UPDATED;
        end else if (!last) begin
          mem_re  = 1'b1;
          rd_addr = idx_inc[IdxW-1:0];
          idx_d   = idx_inc[IdxW-1:0];
        end
      end
      ST_MISS: begin
        if (full) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.outcome     = OUT_FULL;
          out_d.entry_count = 5'(used_q);
        end else begin
          slot_d = used_q[IdxW-1:0];
          used_d = used_q + CntW'(1);
          avg_d  = '0;
          cnt_d  = '0;
          kind_d = OUT_INSERTED;
        end
      end
      ST_READ: begin
        out_valid_d       = 1'b1;
        out_d.outcome     = OUT_READ_OK;
        out_d.slot        = 4'(slot_q);
        out_d.mac         = rd_data_q.mac;
        out_d.avg         = rd_data_q.avg;
        out_d.count       = rd_data_q.cnt;
        out_d.entry_count = 5'(used_q);
      end
      ST_MUL: begin
        prod_d = a_ext * c_ext;
      end
      ST_PREP: begin
        neg_d  = sum[24];
        rem_d  = sum[24] ? $unsigned(-sum) : $unsigned(sum);
        dsh_d  = 25'(dvs) << 7;
        quo_d  = '0;
        step_d = '0;
      end
      ST_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d  = {quo_q[6:0], ge};
        dsh_d  = dsh_q >> 1;
        step_d = step_q + 3'd1;
      end
      ST_WRITE: begin
        mem_we            = 1'b1;
        out_valid_d       = 1'b1;
        out_d.outcome     = kind_q;
        out_d.slot        = 4'(slot_q);
        out_d.mac         = cmd_q.mac;
        out_d.avg         = new_avg;
        out_d.count       = new_cnt;
        out_d.entry_count = 5'(used_q);
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    slot_q <= slot_d;
    kind_q <= kind_d;
    avg_q  <= avg_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    out_q  <= out_d;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_q[slot_q] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= table_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sniffed_frame_source_rssi_table_core.sv
// ----------------------------------------------------------------------------
// sniffed_frame_source_rssi_table_core
// Tracks the running average rssi and frame count of source addresses seen in
// sniffed 802.11 data frames; also clears the table and reads single slots.
// ----------------------------------------------------------------------------
// channel   direction  beat
// s_axis    in         one request: frame, clear or read
// m_axis    out        one result per request
//
// filtered, clear and bad-index requests are answered straight from idle;
// reads first fetch the slot. for a frame the search reads one entry per
// cycle; a hit or an insert then takes one multiply, a sign fixup and an
// 8-step restoring divide, while a miss on a full table is dropped.
// reset empties the table at once; no clearing pass is needed.
// a two-beat queue lets the input side accept while the engine works; the
// result register holds a finished beat until m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sniffed_frame_source_rssi_table_core #(
  parameter int unsigned TableDepth = sfrt_pkg::TableDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: signal_length[11:0], frame_control[27:12], source_mac[75:28],
  //        signal_strength[83:76], read_index[87:84]
  // tuser: req_type[1:0], is_data_frame[2]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,
  input  wire logic [2:0]  s_axis_tuser,
  // tdata: slot_index[3:0], entry_mac[51:4], average_strength[59:52],
  //        frame_count[75:60], entry_count[80:76], zero[87:81]
  // tuser: outcome[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser
);
  import sfrt_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, q_full, q_empty, pop;
  res_t res;

  sfrt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (push),
    .q_cmd_o       (push_cmd)
  );

  sfrt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  sfrt_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.entry_count, res.count, res.avg, res.mac, res.slot};
  assign m_axis_tuser = res.outcome;

endmodule

`default_nettype wire

FILE: tb/sv/sniffed_frame_source_rssi_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sniffed_frame_source_rssi_table_core_tb
// Drives frame, clear and read requests into the rssi table with random gaps
// and back-pressure. Each result is checked against a local table model that
// filters frames, looks up or inserts the source, and keeps the running
// average and the saturating frame count per slot.
// ----------------------------------------------------------------------------
module sniffed_frame_source_rssi_table_core_tb;
  import sfrt_pkg::*;

  localparam int TABLE_SLOTS = TableDepthDefault;
  localparam int MAC_POOL = 24;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]        req;
    logic              is_data;
    logic [11:0]       len;
    logic [15:0]       fc;
    logic [47:0]       mac;
    logic signed [7:0] rssi;
    logic [3:0]        ridx;
  } sniff_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // local copy of the table
  logic [47:0]       mac_tbl [TABLE_SLOTS];
  logic signed [7:0] avg_tbl [TABLE_SLOTS];
  logic [15:0]       cnt_tbl [TABLE_SLOTS];
  int                used_slots = 0;

  res_t pending_table_results[$];
  int   mismatches = 0;
  int   tx_mode = 0;
  int   rx_mode = 0;
  int   rx_stall = 0;
  int   idle_cycles = 0;

  sniffed_frame_source_rssi_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic res_t predict_table_result(input sniff_req_t r);
    res_t res;
    int   hit;
    int   sum;
    logic accepted;
    res = '0;
    hit = -1;
    accepted = r.is_data && (r.len >= MinFrameLen) &&
               (r.fc[FcTypeLsb +: 2] == FcTypeData) &&
               !r.fc[FcToDsBit] && !r.fc[FcFromDsBit] && !r.mac[MacGroupBit];
    if (r.req == REQ_CLEAR) begin
      used_slots = 0;
      res.outcome = OUT_CLEARED;
    end else if (r.req == REQ_READ) begin
      if (int'(r.ridx) < used_slots) begin
        res.outcome = OUT_READ_OK;
        hit = int'(r.ridx);
      end else begin
        res.outcome = OUT_BAD_INDEX;
      end
    end else if (r.req != REQ_FRAME || !accepted) begin
      res.outcome = OUT_FILTERED;
    end else begin
      for (int i = 0; i < used_slots; i++) begin
        if (hit < 0 && mac_tbl[i] == r.mac) hit = i;
      end
      res.outcome = OUT_UPDATED;
      if (hit < 0) begin
        if (used_slots >= TABLE_SLOTS) begin
          res.outcome = OUT_FULL;
        end else begin
          hit = used_slots;
          used_slots++;
          mac_tbl[hit] = r.mac;
          avg_tbl[hit] = '0;
          cnt_tbl[hit] = '0;
          res.outcome = OUT_INSERTED;
        end
      end
      if (hit >= 0) begin
        sum = int'(avg_tbl[hit]) * int'(cnt_tbl[hit]) + int'(r.rssi);
        avg_tbl[hit] = 8'(sum / (int'(cnt_tbl[hit]) + 1));
        if (cnt_tbl[hit] != CountMax) cnt_tbl[hit] = cnt_tbl[hit] + 16'd1;
      end
    end
    if (hit >= 0) begin
      res.slot  = 4'(hit);
      res.mac   = mac_tbl[hit];
      res.avg   = avg_tbl[hit];
      res.count = cnt_tbl[hit];
    end
    res.entry_count = 5'(used_slots);
    return res;
  endfunction

  // mostly short gaps, a few long ones in mode 2
  function automatic int pick_gap(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0 || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (mode == 2) return $urandom_range(8, 40);
    return $urandom_range(4, 6);
  endfunction

  function automatic sniff_req_t random_req(input logic [1:0] req);
    sniff_req_t r;
    r.req     = req;
    r.is_data = 1'($urandom);
    r.len     = 12'($urandom);
    r.fc      = 16'($urandom);
    r.mac     = {16'($urandom), 32'($urandom)};
    r.rssi    = 8'($urandom);
    r.ridx    = 4'($urandom);
    return r;
  endfunction

  function automatic logic [47:0] unicast_mac();
    logic [47:0] m;
    m = {16'($urandom), 32'($urandom)};
    m[MacGroupBit] = 1'b0;
    return m;
  endfunction

  // well-formed data frame, other frame-control bits random
  function automatic sniff_req_t data_frame(input logic [47:0] mac,
                                            input logic signed [7:0] rssi,
                                            input logic [11:0] len);
    sniff_req_t r;
    r = random_req(REQ_FRAME);
    r.is_data = 1'b1;
    r.len     = len;
    r.fc[FcTypeLsb +: 2] = FcTypeData;
    r.fc[FcToDsBit]      = 1'b0;
    r.fc[FcFromDsBit]    = 1'b0;
    r.mac     = mac;
    r.rssi    = rssi;
    return r;
  endfunction

  function automatic sniff_req_t read_req(input logic [3:0] idx);
    sniff_req_t r;
    r = random_req(REQ_READ);
    r.ridx = idx;
    return r;
  endfunction

  task automatic send_req(input sniff_req_t r);
    int gap;
    gap = pick_gap(tx_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.ridx, r.rssi, r.mac, r.fc, r.len};
    s_axis_tuser  <= {r.is_data, r.req};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_table_results.push_back(predict_table_result(r));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_table_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall = pick_gap(rx_mode);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_table_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual tuser %0h tdata %0h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_table_results.pop_front();
        check_field("outcome", 64'(want.outcome), 64'(m_axis_tuser));
        check_field("slot_index", 64'(want.slot), 64'(m_axis_tdata[3:0]));
        check_field("entry_mac", 64'(want.mac), 64'(m_axis_tdata[51:4]));
        check_field("average_strength", 64'($unsigned(want.avg)),
                    64'(m_axis_tdata[59:52]));
        check_field("frame_count", 64'(want.count), 64'(m_axis_tdata[75:60]));
        check_field("entry_count", 64'(want.entry_count), 64'(m_axis_tdata[80:76]));
        check_field("tdata pad", 64'd0, 64'(m_axis_tdata[87:81]));
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("sniffed_frame_source_rssi_table_core regression: fail");
      $finish;
    end
  end

  task automatic test_directed_cases();
    sniff_req_t r;
    logic [47:0] mac_a;
    tx_mode = 1;
    rx_mode = 1;
    mac_a = 48'h0A1B_2C3D_4E5F;
    send_req(read_req(4'd0));
    r = data_frame(mac_a, 8'sd5, 12'd100);
    r.is_data = 1'b0;
    send_req(r);
    send_req(data_frame(mac_a, 8'sd5, 12'd23));
    send_req(data_frame(mac_a, 8'sd5, 12'd0));
    // management, control and extension types
    for (int t = 0; t < 4; t++) begin
      if (2'(t) != FcTypeData) begin
        r = data_frame(mac_a, 8'sd5, 12'd64);
        r.fc[FcTypeLsb +: 2] = 2'(t);
        send_req(r);
      end
    end
    r = data_frame(mac_a, 8'sd5, 12'd64);
    r.fc[FcToDsBit] = 1'b1;
    send_req(r);
    r = data_frame(mac_a, 8'sd5, 12'd64);
    r.fc[FcFromDsBit] = 1'b1;
    send_req(r);
    send_req(data_frame(48'h0100_0000_0000, 8'sd5, 12'd64));
    r = data_frame(mac_a, 8'sd5, 12'd64);
    r.req = REQ_UNKNOWN;
    send_req(r);
    // running average with truncation toward zero
    send_req(data_frame(mac_a, -8'sd128, 12'd4095));
    send_req(data_frame(mac_a, 8'sd127, 12'd4095));
    send_req(data_frame(mac_a, -8'sd1, 12'd200));
    send_req(data_frame(48'hFEFF_FFFF_FFFF, 8'sd127, 12'd24));
    send_req(data_frame(48'h0, 8'sd0, 12'd24));
    send_req(read_req(4'd0));
    send_req(read_req(4'd1));
    send_req(read_req(4'd2));
    send_req(read_req(4'd3));
    send_req(read_req(4'd15));
    send_req(random_req(REQ_CLEAR));
    send_req(read_req(4'd0));
  endtask

  task automatic test_full_table();
    logic [47:0] fill_macs [TABLE_SLOTS];
    tx_mode = 2;
    rx_mode = 0;
    send_req(random_req(REQ_CLEAR));
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      fill_macs[i] = unicast_mac();
      fill_macs[i][3:0] = 4'(i);
      send_req(data_frame(fill_macs[i], 8'($urandom), 12'($urandom_range(24, 4095))));
    end
    for (int i = 0; i < 3; i++) begin
      send_req(data_frame(fill_macs[i] ^ 48'h10_0000, 8'($urandom), 12'd500));
    end
    send_req(data_frame(fill_macs[0], 8'sd127, 12'd4095));
    send_req(data_frame(fill_macs[TABLE_SLOTS-1], -8'sd128, 12'd24));
    for (int i = 0; i < TABLE_SLOTS; i++) send_req(read_req(4'(i)));
    drain_results();
    send_req(random_req(REQ_CLEAR));
  endtask

  task automatic test_random_traffic();
    logic [47:0] mac_pool [MAC_POOL];
    sniff_req_t  r;
    int          roll;
    for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = unicast_mac();
    for (int chunk = 0; chunk < 11; chunk++) begin
      tx_mode = chunk % 3;
      rx_mode = (chunk / 3) % 3;
      if (chunk == 5) drain_results();
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          r = data_frame(mac_pool[$urandom_range(0, MAC_POOL - 1)], 8'($urandom),
                         12'($urandom_range(24, 4095)));
        end else if (roll < 82) begin
          r = read_req(4'($urandom));
        end else if (roll < 84) begin
          r = random_req(REQ_CLEAR);
        end else if (roll < 86) begin
          r = random_req(REQ_UNKNOWN);
        end else begin
          r = data_frame(mac_pool[$urandom_range(0, MAC_POOL - 1)], 8'($urandom),
                         12'($urandom_range(24, 4095)));
          case ($urandom_range(0, 5))
            0: r = random_req(REQ_FRAME);
            1: r.is_data = 1'b0;
            2: r.len = 12'($urandom_range(0, 23));
            3: r.fc[FcTypeLsb +: 2] = FcTypeData ^ 2'($urandom_range(1, 3));
            4: r.fc[FcToDsBit +: 2] = 2'($urandom_range(1, 3));
            default: r.mac[MacGroupBit] = 1'b1;
          endcase
        end
        send_req(r);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_cases();
    test_full_table();
    test_random_traffic();
    drain_results();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sniffed_frame_source_rssi_table_core regression: pass");
    end else begin
      $display("sniffed_frame_source_rssi_table_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: sniffed_frame_source_rssi_table_core.f
hw/rtl/sfrt_pkg.sv
hw/rtl/sfrt_front.sv
hw/rtl/sfrt_queue.sv
hw/rtl/sfrt_back.sv
hw/rtl/sniffed_frame_source_rssi_table_core.sv
tb/sv/sniffed_frame_source_rssi_table_core_tb.sv
